// File: sv/ufd_pkg.sv
// Package for the UTF-8 stream decoder: field widths, byte-class constants,
// and helper functions shared by the decoder modules and interfaces.
// Depends on nothing.
`default_nettype none

package ufd_pkg;

  localparam int unsigned ByteW           = 8;
  localparam int unsigned CpW             = 31;
  localparam int unsigned ContBitsW       = 6;
  localparam int unsigned MaxContBytesDef = 5;
  localparam int unsigned QueueDepthDef   = 4;

  localparam logic [7:0] AsciiLimit = 8'h80;
  localparam logic [7:0] ContMask   = 8'hC0;
  localparam logic [7:0] ContTag    = 8'h80;
  localparam logic [7:0] PayloadAll = 8'h3F;

  function automatic int unsigned cnt_width(int unsigned mc);
    return $clog2(mc + 1);
  endfunction

  function automatic int unsigned job_width(int unsigned mc);
    return 1 + ByteW + cnt_width(mc) + ContBitsW * (mc - 1) + 1 + CpW + 1 + 1;
  endfunction

  function automatic logic [2:0] cont_needed(logic [7:0] b);
    logic [2:0] n;
    if (b < 8'hC0) n = 3'd0;
    else if (b < 8'hE0) n = 3'd1;
    else if (b < 8'hF0) n = 3'd2;
    else if (b < 8'hF8) n = 3'd3;
    else if (b < 8'hFC) n = 3'd4;
    else if (b < 8'hFE) n = 3'd5;
    else n = 3'd0;
    return n;
  endfunction

endpackage

`default_nettype wire

// File: sv/ufd_if.sv
// Handshake interfaces for the UTF-8 stream decoder: the byte input channel
// and the code point output channel. Depends on ufd_pkg.
`default_nettype none

interface ufd_byte_if import ufd_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;
  logic             stream_end;

  modport source (output valid, in_byte, stream_end, input ready);
  modport sink   (input valid, in_byte, stream_end, output ready);
endinterface

interface ufd_cp_if import ufd_pkg::*;;
  logic           valid;
  logic           ready;
  logic [CpW-1:0] code_point;
  logic           passthrough;
  logic           run_last;
  logic           stream_last;

  modport source (output valid, code_point, passthrough, run_last, stream_last, input ready);
  modport sink   (input valid, code_point, passthrough, run_last, stream_last, output ready);
endinterface

`default_nettype wire

// File: sv/ufd_front.sv
// Front end of the UTF-8 stream decoder: accepts bytes, tracks the open
// sequence and emits one job per byte that causes results. Depends on ufd_pkg.
`default_nettype none

module ufd_front import ufd_pkg::*; #(
  parameter int unsigned MaxContBytes = MaxContBytesDef,
  localparam int unsigned CntW = cnt_width(MaxContBytes),
  localparam int unsigned RpW  = ContBitsW * (MaxContBytes - 1),
  localparam int unsigned JobW = job_width(MaxContBytes)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  ufd_byte_if.sink             in_i,
  input  wire logic            full_i,
  output logic                 push_o,
  output logic [JobW-1:0]      job_o
);

  typedef struct packed {
    logic             rp_en;
    logic [ByteW-1:0] rp_lead;
    logic [CntW-1:0]  rp_cnt;
    logic [RpW-1:0]   rp_bytes;
    logic             fin_en;
    logic [CpW-1:0]   fin_cp;
    logic             fin_pt;
    logic             eos;
  } job_t;

  logic [ByteW-1:0] lead_q, lead_d;
  logic [CpW-1:0]   partial_q, partial_d;
  logic [CntW-1:0]  needed_q, needed_d;
  logic [CntW-1:0]  taken_q, taken_d;
  job_t             job;
  logic             accept;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    logic [7:0]      b;
    logic            eos;
    logic            do_start;
    logic [CpW-1:0]  part_ext;
    logic [CntW-1:0] taken_inc;
    logic [2:0]      n;
    b         = in_i.in_byte;
    eos       = in_i.stream_end;
    do_start  = 1'b0;
    part_ext  = {partial_q[CpW-ContBitsW-1:0], b[ContBitsW-1:0]};
    taken_inc = taken_q + 1'b1;
    n         = cont_needed(b);
    lead_d    = lead_q;
    partial_d = partial_q;
    needed_d  = needed_q;
    taken_d   = taken_q;
    job       = '0;
    job.eos   = eos;

    if (needed_q != '0) begin
      if ((b & ContMask) == ContTag) begin
        if (taken_inc >= needed_q) begin
          job.fin_en = 1'b1;
          job.fin_cp = part_ext;
          needed_d   = '0;
        end else if (eos) begin
          job.rp_en    = 1'b1;
          job.rp_lead  = lead_q;
          job.rp_cnt   = taken_inc;
          job.rp_bytes = part_ext[RpW-1:0];
        end else begin
          partial_d = part_ext;
          taken_d   = taken_inc;
        end
      end else begin
        job.rp_en    = 1'b1;
        job.rp_lead  = lead_q;
        job.rp_cnt   = taken_q;
        job.rp_bytes = partial_q[RpW-1:0];
        needed_d     = '0;
        do_start     = 1'b1;
      end
    end else begin
      do_start = 1'b1;
    end

    if (do_start) begin
      if (b < AsciiLimit) begin
        job.fin_en = 1'b1;
        job.fin_cp = CpW'(b);
      end else if (n == 3'd0 || n > 3'(MaxContBytes) || eos) begin
        job.fin_en = 1'b1;
        job.fin_cp = CpW'(b);
        job.fin_pt = 1'b1;
      end else begin
        lead_d    = b;
        partial_d = CpW'(b & (PayloadAll >> n));
        needed_d  = n[CntW-1:0];
        taken_d   = '0;
      end
    end

    if (eos) begin
      needed_d = '0;
    end
  end

  assign push_o = accept && (job.rp_en || job.fin_en);
  assign job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q    <= '0;
      partial_q <= '0;
      needed_q  <= '0;
      taken_q   <= '0;
    end else if (accept) begin
      lead_q    <= lead_d;
      partial_q <= partial_d;
      needed_q  <= needed_d;
      taken_q   <= taken_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/ufd_queue.sv
// Small register queue of decode jobs between the front and back ends of
// the UTF-8 stream decoder. Uses ufd_pkg for its default width and depth.
`default_nettype none

module ufd_queue import ufd_pkg::*; #(
  parameter int unsigned Width = job_width(MaxContBytesDef),
  parameter int unsigned Depth = QueueDepthDef,
  localparam int unsigned Aw = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Aw-1:0]    wptr_q, rptr_q;
  logic [Aw:0]      count_q;

  assign full_o  = (count_q == (Aw + 1)'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == Aw'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == Aw'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/ufd_back.sv
// UTF-8 stream decoder back end (needs ufd_pkg): expands each job into its
// code point words, one per cycle unless stalled, into an output register.
`default_nettype none

module ufd_back import ufd_pkg::*; #(
  parameter int unsigned MaxContBytes = MaxContBytesDef,
  localparam int unsigned CntW = cnt_width(MaxContBytes),
  localparam int unsigned RpW  = ContBitsW * (MaxContBytes - 1),
  localparam int unsigned JobW = job_width(MaxContBytes),
  localparam int unsigned PosW = $clog2(MaxContBytes + 2)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [JobW-1:0] job_i,
  input  wire logic            empty_i,
  output logic                 pop_o,
  ufd_cp_if.source             out_o
);

  typedef struct packed {
    logic             rp_en;
    logic [ByteW-1:0] rp_lead;
    logic [CntW-1:0]  rp_cnt;
    logic [RpW-1:0]   rp_bytes;
    logic             fin_en;
    logic [CpW-1:0]   fin_cp;
    logic             fin_pt;
    logic             eos;
  } job_t;

  job_t           job;
  logic [PosW-1:0] pos_q;
  logic [PosW-1:0] total;
  logic [PosW-1:0] idx;
  logic [RpW-1:0]  shifted;
  logic            in_replay;
  logic            is_last;
  logic            load;
  logic [CpW-1:0]  cur_cp;
  logic            cur_pt;

  logic           valid_q;
  logic [CpW-1:0] cp_q;
  logic           pt_q;
  logic           run_last_q;
  logic           stream_last_q;

  assign job       = job_t'(job_i);
  assign total     = (job.rp_en ? PosW'(job.rp_cnt) + 1'b1 : '0) + PosW'(job.fin_en);
  assign is_last   = (pos_q == total - 1'b1);
  assign in_replay = job.rp_en && (pos_q <= PosW'(job.rp_cnt));
  assign idx       = PosW'(job.rp_cnt) - pos_q;
  assign shifted   = job.rp_bytes >> (ContBitsW * idx);

  always_comb begin
    if (in_replay) begin
      cur_pt = 1'b1;
      if (pos_q == '0) begin
        cur_cp = CpW'(job.rp_lead);
      end else begin
        cur_cp = CpW'({ContTag[7:6], shifted[ContBitsW-1:0]});
      end
    end else begin
      cur_cp = job.fin_cp;
      cur_pt = job.fin_pt;
    end
  end

  assign load  = !empty_i && (!valid_q || out_o.ready);
  assign pop_o = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        pos_q   <= is_last ? '0 : pos_q + 1'b1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cp_q          <= cur_cp;
      pt_q          <= cur_pt;
      run_last_q    <= is_last;
      stream_last_q <= is_last && job.eos;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.code_point  = cp_q;
  assign out_o.passthrough = pt_q;
  assign out_o.run_last    = run_last_q;
  assign out_o.stream_last = stream_last_q;

endmodule

`default_nettype wire

// File: sv/utf8_stream_decoder_unit.sv
// Top level of the UTF-8 stream decoder: front end, job queue and back end.
// Depends on ufd_pkg, ufd_if, ufd_front, ufd_queue and ufd_back.
//
// Bytes enter on in_i (in_byte, stream_end) and decoded code points leave on
// out_o (code_point, passthrough, run_last, stream_last); both use valid and
// ready. Lead bytes C0..FD open sequences of up to five continuation bytes.
// A broken sequence is replayed byte by byte as raw values.
// The front end takes one byte per cycle while the job queue has room and
// writes one job for each byte that produces words. The back end turns a job
// into one to six words, one per cycle while the receiver is ready, into an
// output register. A word reaches out_o through the queue and the output
// register. Bytes that each give at most one word flow at one per cycle
// while the receiver is ready; a broken sequence holds the back end for each
// replayed word in turn, and the queue absorbs that while it has space.
// When the receiver stalls, the output register holds its word and the queue
// fills; in_i.ready drops once the queue is full.
// Reset clears the open sequence, the queue and the output register.
`default_nettype none

module utf8_stream_decoder_unit import ufd_pkg::*; #(
  parameter int unsigned MaxContBytes = MaxContBytesDef,
  parameter int unsigned QueueDepth   = QueueDepthDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ufd_byte_if.sink  in_i,
  ufd_cp_if.source  out_o
);

  localparam int unsigned JobW = job_width(MaxContBytes);

  logic            push;
  logic            pop;
  logic            full;
  logic            empty;
  logic [JobW-1:0] job_in;
  logic [JobW-1:0] job_out;

  ufd_front #(.MaxContBytes(MaxContBytes)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .job_o  (job_in)
  );

  ufd_queue #(.Width(JobW), .Depth(QueueDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (job_out),
    .empty_o (empty)
  );

  ufd_back #(.MaxContBytes(MaxContBytes)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .job_i   (job_out),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire
